// ===== src/gcdlcm_pkg.sv =====
// Shared payload types for the GCD/LCM block.
`timescale 1ns / 1ps

package gcdlcm_pkg;

  localparam int unsigned GCDLCM_OPND_W = 32;
  localparam int unsigned GCDLCM_DIV_W  = 32;
  localparam int unsigned GCDLCM_MUL_W  = 64;

  typedef struct packed {
    logic [GCDLCM_OPND_W-1:0] first_operand;
    logic [GCDLCM_OPND_W-1:0] second_operand;
  } gcdlcm_in_t;

  typedef struct packed {
    logic [GCDLCM_DIV_W-1:0] divisor;
    logic [GCDLCM_MUL_W-1:0] multiple;
    logic                    zero_operand_error;
  } gcdlcm_out_t;

endpackage

// ===== src/gcd_lcm_subtractive.sv =====
// GCD and LCM of an operand pair through a shared subtract/shift sequencer.
//
// Usage: an input beat on in_valid/in_ready carries two unsigned operands,
// of which the low OPERAND_WIDTH bits are used. One result beat follows on
// out_valid/out_ready with the greatest common divisor, the least common
// multiple and an error flag that is set, with both results 0, when either
// operand is zero. One pair is in work at a time; in_ready is high only
// while the sequencer is idle.
// Steps: a zero operand goes straight to the result register. Otherwise
// common factors of two are removed, the subtract/shift reduction runs
// (data dependent), the first operand is divided by the divisor one
// quotient bit a cycle, the quotient is multiplied by the second operand,
// and the result register is loaded. The shared subtractor sets the
// pace.
// The result register parts the channels: the next pair is taken while a
// result still waits. A pair that finishes while the receiver stalls holds
// in its last step until the result register frees.
// Reset: rst_n low at a clock edge empties the result register and returns
// the sequencer to idle.
`timescale 1ns / 1ps

module gcd_lcm_subtractive #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  gcdlcm_pkg::gcdlcm_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gcdlcm_pkg::gcdlcm_out_t out_data
);

  import gcdlcm_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_STRIP  = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_MULT   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]    g_r, g_nxt;
  logic [W-1:0]    quot_r, quot_nxt;
  logic [W-1:0]    opb_r, opb_nxt;
  logic [2*W-1:0]  prod_r, prod_nxt;
  logic            err_r, err_nxt;
  logic            out_valid_r, out_valid_nxt;
  gcdlcm_out_t     out_data_r, out_data_nxt;

  logic [W-1:0]    in_a, in_b;
  logic            a_gt;
  logic [W:0]      op_x, op_y, diff;
  logic            ge;
  logic [W:0]      shifted;

  assign in_a     = in_data.first_operand[W-1:0];
  assign in_b     = in_data.second_operand[W-1:0];
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign a_gt    = (a_r > b_r);
  assign shifted = {a_r, quot_r[W-1]};

  always_comb begin
    if (state_r == ST_DIVIDE) begin
      op_x = shifted;
      op_y = {1'b0, g_r};
    end else if (a_gt) begin
      op_x = {1'b0, a_r};
      op_y = {1'b0, b_r};
    end else begin
      op_x = {1'b0, b_r};
      op_y = {1'b0, a_r};
    end
  end

  assign diff = op_x - op_y;
  assign ge   = (op_x >= op_y);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    g_nxt         = g_r;
    quot_nxt      = quot_r;
    opb_nxt       = opb_r;
    prod_nxt      = prod_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt    = in_a;
          b_nxt    = in_b;
          quot_nxt = in_a;
          opb_nxt  = in_b;
          k_nxt    = '0;
          if ((in_a == '0) || (in_b == '0)) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + CW'(1);
        end else begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (a_r == b_r) begin
          g_nxt     = a_r << k_r;
          a_nxt     = '0;
          cnt_nxt   = CW'(W);
          state_nxt = ST_DIVIDE;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_gt) begin
          a_nxt = diff[W-1:0];
        end else begin
          b_nxt = diff[W-1:0];
        end
      end
      ST_DIVIDE: begin
        a_nxt    = ge ? diff[W-1:0] : shifted[W-1:0];
        quot_nxt = {quot_r[W-2:0], ge};
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        prod_nxt  = quot_r * opb_r;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.zero_operand_error = err_r;
          out_data_nxt.divisor  = err_r ? '0 : GCDLCM_DIV_W'(g_r);
          out_data_nxt.multiple = err_r ? '0 : GCDLCM_MUL_W'(prod_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    g_r        <= g_nxt;
    quot_r     <= quot_nxt;
    opb_r      <= opb_nxt;
    prod_r     <= prod_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
